@@ sv/pbfpc_pkg.sv @@
// Shared constants, codes and control types of the pageblock free page counters.
`default_nettype none
package pbfpc_pkg;

  // Table geometry
  localparam int unsigned BLOCK_ORDER = 9;
  localparam int unsigned NUM_BLOCKS  = 1024;
  localparam int unsigned BLOCK_SIZE  = 1 << BLOCK_ORDER;
  localparam int unsigned AW          = $clog2(NUM_BLOCKS);
  localparam int unsigned IDX_W       = 32 - BLOCK_ORDER;

  // Field widths
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned ORDER_W = 4;
  localparam int unsigned MTYPE_W = 3;
  localparam int unsigned CNT_W   = 32;
  // Largest run is 2^(2^ORDER_W - 1) pages
  localparam int unsigned PAGES_W = 16;

  // Stream payload widths
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 72;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_BASE_FRAME = 1'b0;
  localparam logic        REG_THRESHOLD  = 1'b1;
  localparam logic [MTYPE_W-1:0] THRESHOLD_RST = 3'd1;

  typedef enum logic [1:0] {
    OP_TAKE  = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clearing;    // zero the entry at the clear counter
    logic load_item;   // item accepted this cycle
    logic upd_first;   // update the first entry, read the second
    logic upd_second;  // update the second entry
    logic load_out;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_done;  // last entry is being cleared
  } sts_t;

endpackage
`default_nettype wire

@@ sv/pbfpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbfpc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/pbfpc_ctrl.sv @@
// Controller of the pageblock counters: clearing pass, item sequencing, output valid.
`default_nettype none
module pbfpc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire pbfpc_pkg::sts_t sts_i,
  output pbfpc_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_SECOND,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Output register can take a result now
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clearing = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd_o.upd_first = 1'b1;
        state_d         = ST_SECOND;
      end
      ST_SECOND: begin
        cmd_o.upd_second = 1'b1;
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

@@ sv/pbfpc_dp.sv @@
// Datapath of the pageblock counters: index math, counter table, update adders, result.
`default_nettype none
module pbfpc_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pbfpc_pkg::cmd_t                      cmd_i,
  output pbfpc_pkg::sts_t                           sts_o,
  input  wire logic [pbfpc_pkg::FRAME_W-1:0]        base_frame_i,
  input  wire logic [pbfpc_pkg::MTYPE_W-1:0]        threshold_i,
  input  wire logic [1:0]                           operation_i,
  input  wire logic [pbfpc_pkg::FRAME_W-1:0]        frame_i,
  input  wire logic [pbfpc_pkg::ORDER_W-1:0]        order_i,
  input  wire logic [pbfpc_pkg::MTYPE_W-1:0]        migrate_type_i,
  output logic signed [pbfpc_pkg::CNT_W-1:0]        free_count_o,
  output logic signed [pbfpc_pkg::CNT_W-1:0]        kernel_count_o,
  output logic                                      range_error_o
);

  localparam int unsigned BO    = pbfpc_pkg::BLOCK_ORDER;
  localparam int unsigned AW    = pbfpc_pkg::AW;
  localparam int unsigned IDX_W = pbfpc_pkg::IDX_W;
  localparam int unsigned PW    = pbfpc_pkg::PAGES_W;
  localparam int unsigned CW    = pbfpc_pkg::CNT_W;
  localparam int unsigned FW    = pbfpc_pkg::FRAME_W;
  localparam logic [IDX_W:0]  NB_X      = (IDX_W + 1)'(pbfpc_pkg::NUM_BLOCKS);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(pbfpc_pkg::NUM_BLOCKS - 1);
  localparam logic [BO:0]     BSIZE_X   = (BO + 1)'(pbfpc_pkg::BLOCK_SIZE);

  pbfpc_pkg::op_e op;

  // Accept-time index and split computation
  logic [FW-1:0]  aligned;
  logic [FW-1:0]  offset;
  logic [IDX_W:0] idx1;
  logic [IDX_W:0] idx2;
  logic [PW-1:0]  pages;
  logic [FW:0]    run_end;
  logic           split;
  logic [PW-1:0]  first_amt;

  assign op        = pbfpc_pkg::op_e'(operation_i);
  assign aligned   = {frame_i[FW-1:BO], {BO{1'b0}}};
  assign offset    = aligned - base_frame_i;
  assign idx1      = {1'b0, offset[FW-1:BO]};
  assign idx2      = idx1 + 1'b1;
  assign pages     = PW'(1) << order_i;
  assign run_end   = {1'b0, frame_i} + (FW + 1)'(pages) - 1'b1;
  assign split     = run_end[FW:BO] != {1'b0, frame_i[FW-1:BO]};
  assign first_amt = PW'(BSIZE_X - {1'b0, frame_i[BO-1:0]});

  // Item registers
  logic          upd_q, alloc_q, kern_q, split_q, in1_q, in2_q;
  logic [PW-1:0] amt1_q, amt2_q;
  logic [AW-1:0] addr1_q, addr2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      upd_q   <= (op == pbfpc_pkg::OP_TAKE) || (op == pbfpc_pkg::OP_FREE);
      alloc_q <= op == pbfpc_pkg::OP_TAKE;
      kern_q  <= migrate_type_i < threshold_i;
      split_q <= split;
      in1_q   <= idx1 < NB_X;
      in2_q   <= idx2 < NB_X;
      amt1_q  <= split ? first_amt : pages;
      amt2_q  <= pages - first_amt;
      addr1_q <= idx1[AW-1:0];
      addr2_q <= idx2[AW-1:0];
    end
  end

  // Clear counter
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clearing) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign sts_o.clear_done = cmd_i.clearing && (clr_cnt_q == LAST_ADDR);

  // Counter table: kernel counter in the upper half, free counter in the lower
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;

  // Read the first entry on the accept edge, the second one while updating the first
  assign ram_raddr = cmd_i.upd_first ? addr2_q : idx1[AW-1:0];

  pbfpc_ram #(
    .Width (2 * CW),
    .Depth (pbfpc_pkg::NUM_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [CW-1:0] amt;
  logic [CW-1:0] rd_free, rd_kern, new_free, new_kern, upd_free, upd_kern;

  assign amt      = CW'(cmd_i.upd_second ? amt2_q : amt1_q);
  assign rd_free  = ram_rdata[CW-1:0];
  assign rd_kern  = ram_rdata[2*CW-1:CW];
  assign upd_free = alloc_q ? rd_free - amt : rd_free + amt;
  assign upd_kern = alloc_q ? rd_kern - amt : rd_kern + amt;
  assign new_free = upd_q ? upd_free : rd_free;
  assign new_kern = (upd_q && kern_q) ? upd_kern : rd_kern;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr1_q;
    ram_wdata = {new_kern, new_free};
    priority if (cmd_i.clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.upd_first) begin
      ram_we = upd_q && in1_q;
    end else if (cmd_i.upd_second) begin
      ram_we    = upd_q && split_q && in2_q;
      ram_waddr = addr2_q;
    end else begin
      ram_we = 1'b0;
    end
  end

  // Result of the first entry, then the output register
  logic [CW-1:0] res_free_q, res_kern_q;
  logic [CW-1:0] out_free_q, out_kern_q;
  logic          out_err_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_first) begin
      res_free_q <= in1_q ? new_free : '0;
      res_kern_q <= in1_q ? new_kern : '0;
    end
    if (cmd_i.load_out) begin
      out_free_q <= res_free_q;
      out_kern_q <= res_kern_q;
      out_err_q  <= !in1_q || (upd_q && split_q && !in2_q);
    end
  end

  assign free_count_o   = out_free_q;
  assign kernel_count_o = out_kern_q;
  assign range_error_o  = out_err_q;

endmodule
`default_nettype wire

@@ sv/pageblock_free_page_counters.sv @@
// Top level of the pageblock free page counters: ports, configuration registers.
`default_nettype none
// Keeps a free-page and a kernel-page counter for each of NUM_BLOCKS pageblocks
// of 2^BLOCK_ORDER frames, starting at base_frame. An item allocates, frees or
// queries a run of 2^order frames; a run that reaches into the next pageblock
// is split between the two entries. After reset a clearing pass zeroes the
// counter memory, one entry per cycle, NUM_BLOCKS entries (1024) in all; no
// item is accepted meanwhile, while configuration writes are taken. Each item
// then passes the FIRST and SECOND states between acceptance and a result in
// the output register, and the next item is accepted only once the previous
// one is back in IDLE: the single-write-port counter memory is read at the
// first entry on the accept edge, the first entry is written back while the
// second is read, and the second entry is written back. A new item is accepted
// while a result still waits in the output register; if that result is still
// waiting when the next one is ready, the next one holds until the output
// register frees up. Write configuration only while the block is idle.
module pageblock_free_page_counters (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // APB configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pbfpc_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [pbfpc_pkg::PDATA_W-1:0]       pwdata,
  output logic      [pbfpc_pkg::PDATA_W-1:0]       prdata,
  output logic                                     pready,
  // Input items
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // operation[1:0], frame[33:2], order[37:34], migrate_type[40:38], zero pad
  input  wire logic [pbfpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Result items
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // free_count[31:0], kernel_count[63:32], range_error[64], zero pad
  output logic      [pbfpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned FW = pbfpc_pkg::FRAME_W;
  localparam int unsigned MW = pbfpc_pkg::MTYPE_W;
  localparam int unsigned CW = pbfpc_pkg::CNT_W;

  // Configuration registers
  logic [FW-1:0] base_frame_q;
  logic [MW-1:0] threshold_q;
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_frame_q <= '0;
      threshold_q  <= pbfpc_pkg::THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pbfpc_pkg::REG_BASE_FRAME: base_frame_q <= pwdata[FW-1:0];
        pbfpc_pkg::REG_THRESHOLD:  threshold_q  <= pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pbfpc_pkg::REG_BASE_FRAME: prdata = base_frame_q;
      pbfpc_pkg::REG_THRESHOLD:  prdata = {{(pbfpc_pkg::PDATA_W - MW){1'b0}}, threshold_q};
      default:                   prdata = '0;
    endcase
  end

  pbfpc_pkg::cmd_t cmd;
  pbfpc_pkg::sts_t sts;

  logic signed [CW-1:0] free_count;
  logic signed [CW-1:0] kernel_count;
  logic                 range_error;

  pbfpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pbfpc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .base_frame_i   (base_frame_q),
    .threshold_i    (threshold_q),
    .operation_i    (s_axis_tdata[1:0]),
    .frame_i        (s_axis_tdata[33:2]),
    .order_i        (s_axis_tdata[37:34]),
    .migrate_type_i (s_axis_tdata[40:38]),
    .free_count_o   (free_count),
    .kernel_count_o (kernel_count),
    .range_error_o  (range_error)
  );

  assign m_axis_tdata = {7'd0, range_error, kernel_count, free_count};

endmodule
`default_nettype wire
